FILE: rtl/tfrb_pkg.sv
// Shared types and constants for the tuning factor register bank.
// Used by the access decoder, the top level and the testbench; no dependencies.
`timescale 1ns / 1ps

package tfrb_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StRange = 2'd1,
    StDeny  = 2'd2
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] CfgLastAddress = 2'd0;
  localparam logic [1:0] CfgBankId      = 2'd1;
  localparam logic [1:0] CfgBankVersion = 2'd2;

  // Byte map of one bank
  localparam logic [7:0] AddrLastAddress = 8'd0;
  localparam logic [7:0] AddrZero        = 8'd1;
  localparam logic [7:0] AddrLock        = 8'd2;
  localparam logic [7:0] AddrBankId      = 8'd3;
  localparam logic [7:0] AddrBankVersion = 8'd4;
  localparam logic [7:0] AddrEnable      = 8'd5;
  localparam logic [7:0] AddrTuning      = 8'd6;
  localparam logic [7:0] AddrTuningMin   = 8'd7;
  localparam logic [7:0] AddrTuningMax   = 8'd8;
  localparam logic [7:0] AddrLumenHi     = 8'd9;
  localparam logic [7:0] AddrLumenMid    = 8'd10;
  localparam logic [7:0] AddrLumenLo     = 8'd11;

  localparam logic [7:0] UnlockKey = 8'h55;

  // Q15 scaling of the tuning factor: (tf * Q15Mul + Q15Round) >> Q15Shift
  localparam logic [17:0] Q15Mul   = 18'd167772;
  localparam logic [25:0] Q15Round = 26'd255;
  localparam int          Q15Shift = 9;

  // One channel's stored state
  typedef struct packed {
    logic [7:0]  lock_byte;
    logic        enable_bit;
    logic [7:0]  tuning_factor;
    logic [7:0]  tuning_min;
    logic [7:0]  tuning_max;
    logic [23:0] lumen_reference;
  } entry_t;

  // Header registers
  typedef struct packed {
    logic [7:0] last_address;
    logic [7:0] bank_id;
    logic [7:0] bank_version;
  } cfg_t;

  // Decoded access handed to the access decoder
  typedef struct packed {
    logic       is_write;
    logic [7:0] address;
    logic [7:0] write_value;
    logic       ch_ok;
    logic       pt_ok;
  } acc_req_t;

  // Port buffer updates
  typedef struct packed {
    logic        rl_we;
    logic [23:0] rl_d;
    logic        wa_we;
    logic [23:0] wa_d;
  } buf_upd_t;

  // Result before Q15 scaling
  typedef struct packed {
    status_e    status;
    logic [7:0] read_data;
    logic       enable_flag;
    logic [7:0] tuning_factor;
  } acc_res_t;

endpackage

FILE: rtl/tfrb_req_if.sv
// Request channel of the tuning factor register bank.
// Depends on nothing; valid/ready handshake with the access fields.
`timescale 1ns / 1ps

interface tfrb_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] address;
  logic [7:0] write_value;
  logic [1:0] channel;
  logic [7:0] port;

  modport source (output valid, req_type, address, write_value, channel, port,
                  input ready);
  modport sink (input valid, req_type, address, write_value, channel, port,
                output ready);
endinterface

FILE: rtl/tfrb_rsp_if.sv
// Response channel of the tuning factor register bank.
// Depends on nothing; valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface tfrb_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  read_data;
  logic        enable_flag;
  logic [16:0] tuning_q15;

  modport source (output valid, status, read_data, enable_flag, tuning_q15,
                  input ready);
  modport sink (input valid, status, read_data, enable_flag, tuning_q15,
                output ready);
endinterface

FILE: rtl/tfrb_access.sv
// Access decoder: applies one read or write to a channel entry and port buffers.
// Depends on tfrb_pkg.
`timescale 1ns / 1ps

module tfrb_access (
  input  tfrb_pkg::acc_req_t req_i,
  input  tfrb_pkg::entry_t   entry_i,
  input  tfrb_pkg::cfg_t     cfg_i,
  input  logic [23:0]        rl_i,
  input  logic [23:0]        wa_i,
  output tfrb_pkg::entry_t   entry_o,
  output logic               entry_we_o,
  output tfrb_pkg::buf_upd_t buf_o,
  output tfrb_pkg::acc_res_t res_o
);
  import tfrb_pkg::*;

  status_e    status;
  logic [7:0] rdata;
  entry_t     nxt;
  logic       we;
  buf_upd_t   bu;
  logic [23:0] assembled;

  always_comb begin
    status    = StOk;
    rdata     = 8'd0;
    nxt       = entry_i;
    we        = 1'b0;
    bu        = '0;
    bu.rl_d   = rl_i;
    bu.wa_d   = wa_i;
    assembled = wa_i | {16'd0, req_i.write_value};

    if (!req_i.ch_ok) begin
      status = StRange;
    end else if (req_i.is_write) begin
      // Lock test comes before the port test
      if (entry_i.lock_byte != UnlockKey && req_i.address != AddrLock) begin
        status = StDeny;
      end else if (!req_i.pt_ok) begin
        status = StRange;
      end else begin
        case (req_i.address)
          AddrLock: begin
            nxt.lock_byte = req_i.write_value;
            we = 1'b1;
          end
          AddrEnable: begin
            nxt.enable_bit = req_i.write_value[0];
            we = 1'b1;
          end
          AddrTuning: begin
            nxt.tuning_factor = req_i.write_value;
            we = 1'b1;
          end
          AddrTuningMin: begin
            nxt.tuning_min = req_i.write_value;
            we = 1'b1;
          end
          AddrTuningMax: begin
            nxt.tuning_max = req_i.write_value;
            we = 1'b1;
          end
          AddrLumenHi: begin
            bu.wa_we = 1'b1;
            bu.wa_d  = {req_i.write_value, 16'd0};
          end
          AddrLumenMid: begin
            bu.wa_we = 1'b1;
            bu.wa_d  = wa_i | {8'd0, req_i.write_value, 8'd0};
          end
          AddrLumenLo: begin
            // Commit the assembled value to the channel
            bu.wa_we = 1'b1;
            bu.wa_d  = assembled;
            nxt.lumen_reference = assembled;
            we = 1'b1;
          end
          default: status = StRange;
        endcase
      end
    end else begin
      if (!req_i.pt_ok) begin
        status = StRange;
      end else begin
        case (req_i.address)
          AddrLastAddress: rdata = cfg_i.last_address;
          AddrZero:        rdata = 8'd0;
          AddrLock:        rdata = entry_i.lock_byte;
          AddrBankId:      rdata = cfg_i.bank_id;
          AddrBankVersion: rdata = cfg_i.bank_version;
          AddrEnable:      rdata = {7'd0, entry_i.enable_bit};
          AddrTuning:      rdata = entry_i.tuning_factor;
          AddrTuningMin:   rdata = entry_i.tuning_min;
          AddrTuningMax:   rdata = entry_i.tuning_max;
          AddrLumenHi: begin
            // Snapshot the lumen value into the port's read latch
            bu.rl_we = 1'b1;
            bu.rl_d  = entry_i.lumen_reference;
            rdata    = entry_i.lumen_reference[23:16];
          end
          AddrLumenMid: rdata = rl_i[15:8];
          AddrLumenLo:  rdata = rl_i[7:0];
          default:      status = StRange;
        endcase
      end
    end
  end

  assign entry_o    = nxt;
  assign entry_we_o = we;
  assign buf_o      = bu;

  // Report the channel's state after the access; zero for a bad channel
  always_comb begin
    res_o.status        = status;
    res_o.read_data     = (status == StOk && !req_i.is_write) ? rdata : 8'd0;
    res_o.enable_flag   = req_i.ch_ok ? nxt.enable_bit : 1'b0;
    res_o.tuning_factor = req_i.ch_ok ? nxt.tuning_factor : 8'd0;
  end

endmodule

FILE: rtl/tuning_factor_register_bank_top.sv
// Top level of the tuning factor register bank.
// Depends on tfrb_pkg, tfrb_req_if, tfrb_rsp_if and tfrb_access.
`timescale 1ns / 1ps

// Each item is handled in order: the channel entry is read from the entry memory
// when the item is accepted, and then it is modified, written back and the
// result is loaded into the output register, once that register is free. No
// new item is accepted until the current item has been written back.
// A result waiting in the output register does not block the next item's read;
// only the write-back stage waits for the output register to free up.
// Entries come out of reset at their default values with no clearing pass.
module tuning_factor_register_bank_top #(
  parameter int CHANNELS   = 4,
  parameter int PORTS      = 1,
  parameter int DEF_TUNING = 100,
  parameter int DEF_MIN    = 50,
  parameter int DEF_MAX    = 150,
  parameter int DEF_LUMEN  = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  tfrb_req_if.sink   req_i,
  tfrb_rsp_if.source rsp_o
);
  import tfrb_pkg::*;

  localparam int MemDepth = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int MemAw    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int PtW      = (PORTS > 1) ? $clog2(PORTS) : 1;

  // Reset contents of one entry, clamped as at power-up
  localparam logic [7:0] RstMax = 8'(DEF_MAX);
  localparam logic [7:0] RstMin = (8'(DEF_MIN) > RstMax) ? RstMax : 8'(DEF_MIN);
  localparam logic [7:0] RstTfLo = (8'(DEF_TUNING) < RstMin) ? RstMin : 8'(DEF_TUNING);
  localparam logic [7:0] RstTf   = (RstTfLo > RstMax) ? RstMax : RstTfLo;
  localparam entry_t RstEntry = '{
    lock_byte:       8'hFF,
    enable_bit:      1'b0,
    tuning_factor:   RstTf,
    tuning_min:      RstMin,
    tuning_max:      RstMax,
    lumen_reference: 24'(DEF_LUMEN)
  };

  // Header registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{last_address: 8'd11, bank_id: 8'd22, bank_version: 8'd0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLastAddress: cfg_q.last_address <= cfg_data_i;
        CfgBankId:      cfg_q.bank_id      <= cfg_data_i;
        CfgBankVersion: cfg_q.bank_version <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake and item registers
  logic       busy_q;
  logic       out_valid_q;
  logic       accept;
  logic       done;
  acc_req_t   acc_q;
  logic [MemAw-1:0] ch_idx_q;
  logic [PtW-1:0]   pt_idx_q;
  logic             ch_ok_in;
  logic             pt_ok_in;

  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign done        = busy_q && (!out_valid_q || rsp_o.ready);
  assign ch_ok_in    = (32'(req_i.channel) < CHANNELS);
  assign pt_ok_in    = (32'(req_i.port) < PORTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  // Capture the item; bad channel or port indexes fold to zero
  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q.is_write    <= req_i.req_type;
      acc_q.address     <= req_i.address;
      acc_q.write_value <= req_i.write_value;
      acc_q.ch_ok       <= ch_ok_in;
      acc_q.pt_ok       <= pt_ok_in;
      ch_idx_q <= ch_ok_in ? req_i.channel[MemAw-1:0] : '0;
      pt_idx_q <= pt_ok_in ? req_i.port[PtW-1:0] : '0;
    end
  end

  // Entry memory with valid bits; an unwritten entry reads as its reset value
  entry_t           entry_mem [MemDepth];
  entry_t           rd_data_q;
  logic             rd_vld_q;
  logic [MemDepth-1:0] vld_q;
  logic [MemAw-1:0] rd_idx;
  entry_t           entry_cur;
  entry_t           entry_nxt;
  logic             entry_we;

  assign rd_idx    = ch_ok_in ? req_i.channel[MemAw-1:0] : '0;
  assign entry_cur = rd_vld_q ? rd_data_q : RstEntry;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q <= entry_mem[rd_idx];
    end
    if (done && entry_we) begin
      entry_mem[ch_idx_q] <= entry_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_q <= vld_q[rd_idx];
      end
      if (done && entry_we) begin
        vld_q[ch_idx_q] <= 1'b1;
      end
    end
  end

  // Per-port read latch and write assembly buffers
  logic [23:0] rl_q [PORTS];
  logic [23:0] wa_q [PORTS];
  buf_upd_t    bu;
  acc_res_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORTS; i++) begin
        rl_q[i] <= 24'd0;
        wa_q[i] <= 24'd0;
      end
    end else if (done) begin
      if (bu.rl_we) begin
        rl_q[pt_idx_q] <= bu.rl_d;
      end
      if (bu.wa_we) begin
        wa_q[pt_idx_q] <= bu.wa_d;
      end
    end
  end

  tfrb_access u_access (
    .req_i      (acc_q),
    .entry_i    (entry_cur),
    .cfg_i      (cfg_q),
    .rl_i       (rl_q[pt_idx_q]),
    .wa_i       (wa_q[pt_idx_q]),
    .entry_o    (entry_nxt),
    .entry_we_o (entry_we),
    .buf_o      (bu),
    .res_o      (res)
  );

  // Scale the tuning factor to Q15
  logic [25:0] q15_prod;
  logic [25:0] q15_sum;

  assign q15_prod = 26'(res.tuning_factor) * 26'(Q15Mul);
  assign q15_sum  = q15_prod + Q15Round;

  // Output register: hold the result until taken
  logic [1:0]  status_q;
  logic [7:0]  read_data_q;
  logic        enable_flag_q;
  logic [16:0] tuning_q15_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q      <= res.status;
      read_data_q   <= res.read_data;
      enable_flag_q <= res.enable_flag;
      tuning_q15_q  <= q15_sum[Q15Shift +: 17];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_data   = read_data_q;
  assign rsp_o.enable_flag = enable_flag_q;
  assign rsp_o.tuning_q15  = tuning_q15_q;

endmodule

FILE: test/tuning_factor_register_bank_top_tb.sv
// Self-checking testbench for the tuning factor register bank top level.
// Depends on tfrb_pkg, tfrb_req_if, tfrb_rsp_if, the top level and the RTL below it.
`timescale 1ns / 1ps

module tuning_factor_register_bank_top_tb;
  import tfrb_pkg::*;

  // Block configuration as instantiated
  localparam int Channels   = 4;
  localparam int Ports      = 1;
  localparam int DefTuning  = 100;
  localparam int DefMin     = 50;
  localparam int DefMax     = 150;
  localparam int DefLumen   = 0;

  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  // Q15 scaling of a tuning factor
  localparam logic [31:0] Q15Gain = 32'd167772;
  localparam logic [31:0] Q15Bias = 32'd255;
  localparam logic [16:0] Q15Reset = 17'd32768;  // tuning factor 100
  localparam logic [16:0] Q15Top   = 17'd83558;  // tuning factor 255

  localparam int IdlePct        = 20;
  localparam int NumPhases      = 6;
  localparam int ItemsPerPhase  = 290;
  localparam int SettleCycles   = 4;
  localparam int StallLimit     = 2000;
  localparam int MaxReports     = 40;

  typedef struct packed {
    logic       req_type;
    logic [7:0] address;
    logic [7:0] write_value;
    logic [1:0] channel;
    logic [7:0] port;
  } access_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  read_data;
    logic        enable_flag;
    logic [16:0] tuning_q15;
  } response_t;

  typedef struct packed {
    access_t   acc;
    logic      typed;
    response_t rsp;
  } directed_row_t;

  localparam int NumDirected = 27;

  // Directed accesses; typed rows carry their result, the others use the predictor
  directed_row_t directed_rows [NumDirected] = '{
    '{'{ReqRead,  AddrLastAddress, 8'h00, 2'd0, 8'd0},   1'b1, '{StOk, 8'd11, 1'b0, Q15Reset}},
    '{'{ReqRead,  AddrZero,        8'h00, 2'd1, 8'd0},   1'b1, '{StOk, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqRead,  AddrLock,        8'h00, 2'd3, 8'd0},   1'b1, '{StOk, 8'd255, 1'b0, Q15Reset}},
    '{'{ReqRead,  AddrBankId,      8'h00, 2'd2, 8'd0},   1'b1, '{StOk, 8'd22, 1'b0, Q15Reset}},
    '{'{ReqRead,  AddrBankVersion, 8'hFF, 2'd0, 8'd0},   1'b1, '{StOk, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqRead,  AddrLumenHi,     8'h00, 2'd1, 8'd0},   1'b1, '{StOk, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqRead,  8'd12,           8'h00, 2'd0, 8'd0},   1'b1, '{StRange, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqRead,  8'hFF,           8'h00, 2'd0, 8'd0},   1'b1, '{StRange, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqRead,  AddrLastAddress, 8'h00, 2'd0, 8'd1},   1'b1, '{StRange, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqWrite, AddrEnable,      8'hFF, 2'd0, 8'd0},   1'b1, '{StDeny, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqWrite, AddrLumenLo,     8'hFF, 2'd3, 8'hFF},  1'b1, '{StDeny, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqWrite, AddrLock,        UnlockKey, 2'd1, 8'hFF},
      1'b1, '{StRange, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqWrite, AddrLock,        UnlockKey, 2'd0, 8'd0}, 1'b1, '{StOk, 8'd0, 1'b0, Q15Reset}},
    '{'{ReqWrite, AddrTuning,      8'hFF, 2'd0, 8'd0},   1'b1, '{StOk, 8'd0, 1'b0, Q15Top}},
    '{'{ReqWrite, AddrTuning,      8'h00, 2'd0, 8'd0},   1'b1, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrEnable,      8'hFE, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrEnable,      8'h01, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrTuningMin,   8'hC8, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrTuningMax,   8'h0A, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrLumenHi,     8'hAB, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrLumenMid,    8'hCD, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrLumenLo,     8'hEF, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqRead,  AddrLumenHi,     8'h00, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqRead,  AddrLumenLo,     8'h00, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrBankId,      8'h00, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrEnable,      8'h01, 2'd0, 8'h80},  1'b0, '{StOk, 8'd0, 1'b0, 17'd0}},
    '{'{ReqWrite, AddrLock,        8'h54, 2'd0, 8'd0},   1'b0, '{StOk, 8'd0, 1'b0, 17'd0}}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;
  bit         calm;

  // Typed expectation of the item currently offered
  logic       row_typed;
  response_t  row_expected;

  tfrb_req_if req_if ();
  tfrb_rsp_if rsp_if ();

  tuning_factor_register_bank_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Predicted bank contents
  logic [7:0]  hdr_last_address;
  logic [7:0]  hdr_bank_id;
  logic [7:0]  hdr_bank_version;
  logic [7:0]  lock_byte     [Channels];
  logic        enable_bit    [Channels];
  logic [7:0]  tuning_factor [Channels];
  logic [7:0]  tuning_min    [Channels];
  logic [7:0]  tuning_max    [Channels];
  logic [23:0] lumen_ref     [Channels];
  logic [23:0] read_latch    [Ports];
  logic [23:0] write_asm     [Ports];

  response_t   expected_q [$];
  int          fail_count;
  int          report_count;

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Apply one access to the predicted bank and return its result
  function automatic response_t bank_response(input access_t a);
    response_t   res;
    int          ch;
    int          pt;
    logic [7:0]  data;
    status_e     st;
    logic [31:0] prod;
    ch   = int'(a.channel);
    pt   = int'(a.port);
    data = 8'd0;
    res  = '{StRange, 8'd0, 1'b0, 17'd0};
    if (ch >= Channels) return res;
    if (a.req_type) begin
      // lock is checked ahead of the port
      if (lock_byte[ch] != UnlockKey && a.address != AddrLock) begin
        st = StDeny;
      end else if (pt >= Ports) begin
        st = StRange;
      end else begin
        st = StOk;
        case (a.address)
          AddrLock:      lock_byte[ch] = a.write_value;
          AddrEnable:    enable_bit[ch] = a.write_value[0];
          AddrTuning:    tuning_factor[ch] = a.write_value;
          AddrTuningMin: tuning_min[ch] = a.write_value;
          AddrTuningMax: tuning_max[ch] = a.write_value;
          AddrLumenHi:   write_asm[pt] = {a.write_value, 16'h0000};
          AddrLumenMid:  write_asm[pt] = write_asm[pt] | {8'h00, a.write_value, 8'h00};
          AddrLumenLo: begin
            write_asm[pt] = write_asm[pt] | {16'h0000, a.write_value};
            lumen_ref[ch] = write_asm[pt];
          end
          default:       st = StRange;
        endcase
      end
    end else begin
      if (pt >= Ports) begin
        st = StRange;
      end else begin
        st = StOk;
        case (a.address)
          AddrLastAddress: data = hdr_last_address;
          AddrZero:        data = 8'd0;
          AddrLock:        data = lock_byte[ch];
          AddrBankId:      data = hdr_bank_id;
          AddrBankVersion: data = hdr_bank_version;
          AddrEnable:      data = {7'd0, enable_bit[ch]};
          AddrTuning:      data = tuning_factor[ch];
          AddrTuningMin:   data = tuning_min[ch];
          AddrTuningMax:   data = tuning_max[ch];
          AddrLumenHi: begin
            read_latch[pt] = lumen_ref[ch];
            data = read_latch[pt][23:16];
          end
          AddrLumenMid:    data = read_latch[pt][15:8];
          AddrLumenLo:     data = read_latch[pt][7:0];
          default:         st = StRange;
        endcase
      end
      if (st != StOk) data = 8'd0;
    end
    prod = 32'(tuning_factor[ch]) * Q15Gain + Q15Bias;
    res.status      = st;
    res.read_data   = a.req_type ? 8'd0 : data;
    res.enable_flag = enable_bit[ch];
    res.tuning_q15  = prod[25:9];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    fail_count++;
    if (report_count < MaxReports) begin
      report_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Offer one item after a random idle gap and hold it until accepted
  task automatic issue_access(input access_t a, input logic typed, input response_t r);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= a.req_type;
    req_if.address     <= a.address;
    req_if.write_value <= a.write_value;
    req_if.channel     <= a.channel;
    req_if.port        <= a.port;
    row_typed          <= typed;
    row_expected       <= r;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic drain_bank();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CfgLastAddress: hdr_last_address = data;
      CfgBankId:      hdr_bank_id = data;
      CfgBankVersion: hdr_bank_version = data;
      default: ;
    endcase
  endtask

  // Receiver stalls at random except in calm phases
  always @(negedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // Predict accepted items and check accepted results
  always @(posedge clk_i) begin : score
    response_t want;
    if (rst_ni && req_if.valid && req_if.ready) begin
      want = bank_response(access_t'{req_if.req_type, req_if.address, req_if.write_value,
                                     req_if.channel, req_if.port});
      if (row_typed) want = row_expected;
      expected_q.push_back(want);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (report_count < MaxReports) begin
          report_count++;
          $display("%0t: result with no item pending, expected none, actual status %0d",
                   $time, rsp_if.status);
        end
      end else begin
        want = expected_q.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", want.status, rsp_if.status);
        if (rsp_if.read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, rsp_if.read_data);
        if (rsp_if.enable_flag !== want.enable_flag)
          report_mismatch("enable_flag", want.enable_flag, rsp_if.enable_flag);
        if (rsp_if.tuning_q15 !== want.tuning_q15)
          report_mismatch("tuning_q15", want.tuning_q15, rsp_if.tuning_q15);
      end
    end
  end

  // Abort when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] tf;
    access_t    a;
    access_t    b;
    access_t    burst_q [$];
    response_t  no_rsp;
    int unsigned pick;

    no_rsp = '{StOk, 8'd0, 1'b0, 17'd0};

    // Known values on every input
    rst_ni             = 1'b0;
    calm               = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CfgLastAddress;
    cfg_data           = 8'd0;
    req_if.valid       = 1'b0;
    req_if.req_type    = ReqRead;
    req_if.address     = 8'd0;
    req_if.write_value = 8'd0;
    req_if.channel     = 2'd0;
    req_if.port        = 8'd0;
    row_typed          = 1'b0;
    row_expected       = no_rsp;
    fail_count         = 0;
    report_count       = 0;

    // Reset state, with the defaults clamped into min/max
    mx = 8'(DefMax);
    mn = 8'(DefMin);
    tf = 8'(DefTuning);
    if (mn > mx) mn = mx;
    if (tf < mn) tf = mn;
    if (tf > mx) tf = mx;
    hdr_last_address = 8'd11;
    hdr_bank_id      = 8'd22;
    hdr_bank_version = 8'd0;
    for (int i = 0; i < Channels; i++) begin
      lock_byte[i]     = 8'hFF;
      enable_bit[i]    = 1'b0;
      tuning_factor[i] = tf;
      tuning_min[i]    = mn;
      tuning_max[i]    = mx;
      lumen_ref[i]     = 24'(DefLumen);
    end
    for (int i = 0; i < Ports; i++) begin
      read_latch[i] = 24'd0;
      write_asm[i]  = 24'd0;
    end

    // Hold reset while the clock runs, then release it at a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < NumDirected; i++) begin
      issue_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].rsp);
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      // Change the header registers while the bank is idle
      if (phase != 0) begin
        drain_bank();
        case (phase)
          1: begin
            write_register(CfgLastAddress, 8'd0);
            write_register(CfgBankId, 8'd0);
            write_register(CfgBankVersion, 8'd0);
          end
          2: begin
            write_register(CfgLastAddress, 8'hFF);
            write_register(CfgBankId, 8'hFF);
            write_register(CfgBankVersion, 8'hFF);
          end
          5: begin
            write_register(CfgLastAddress, 8'd11);
            write_register(CfgBankId, 8'd22);
            write_register(CfgBankVersion, 8'd0);
          end
          default: begin
            write_register(CfgLastAddress, 8'($urandom_range(0, 255)));
            write_register(CfgBankId, 8'($urandom_range(0, 255)));
            write_register(CfgBankVersion, 8'($urandom_range(0, 255)));
          end
        endcase
        @(negedge clk_i);
        cfg_we <= 1'b0;
      end
      calm = (phase == 2);

      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (burst_q.size() != 0) begin
          a = burst_q.pop_front();
        end else begin
          pick          = $urandom_range(0, 99);
          a.req_type    = 1'($urandom_range(0, 1));
          a.address     = 8'($urandom_range(0, 11));
          a.write_value = 8'($urandom_range(0, 255));
          a.channel     = 2'($urandom_range(0, 3));
          a.port        = 8'd0;
          if (pick < 10) begin
            // unlock a channel
            a.req_type    = ReqWrite;
            a.address     = AddrLock;
            a.write_value = UnlockKey;
          end else if (pick < 14) begin
            // overwrite the lock byte, usually locking the channel
            a.req_type = ReqWrite;
            a.address  = AddrLock;
          end else if (pick < 32) begin
            // three-byte lumen transfer, high byte first
            a.address     = AddrLumenHi;
            b             = a;
            b.address     = AddrLumenMid;
            b.write_value = 8'($urandom_range(0, 255));
            burst_q.push_back(b);
            b.address     = AddrLumenLo;
            b.write_value = 8'($urandom_range(0, 255));
            burst_q.push_back(b);
          end else if (pick >= 80) begin
            // noise: any address, often a bad port
            a.address = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) a.port = 8'($urandom_range(0, 255));
          end
        end
        issue_access(a, 1'b0, no_rsp);
      end
    end

    drain_bank();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tfrb_pkg.sv
rtl/tfrb_req_if.sv
rtl/tfrb_rsp_if.sv
rtl/tfrb_access.sv
rtl/tuning_factor_register_bank_top.sv
test/tuning_factor_register_bank_top_tb.sv
